// File: design/c2s_pkg.sv
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared constants, types and the arctangent table of the cartesian to
// spherical converter
// ----------------------------------------------------------------------------
package c2s_pkg;

    localparam int ROTATION_STAGES = 16;
    localparam int COORD_WIDTH     = 24;
    localparam int GUARD_BITS      = 6;
    localparam int TABLE_LEN       = 24;
    localparam int NSTAGE          = (ROTATION_STAGES < TABLE_LEN) ? ROTATION_STAGES : TABLE_LEN;

    localparam int DP_W   = COORD_WIDTH + GUARD_BITS + 3;
    localparam int MAG_W  = DP_W - 1;
    localparam int ACC_W  = 32;
    localparam int ANG_W  = 16;
    localparam int IDX_W  = $clog2(TABLE_LEN);
    localparam int GAIN_W = 30;
    localparam int PROD_W = MAG_W + GAIN_W;
    localparam int LENR_W = MAG_W + 1 - GUARD_BITS;

    localparam logic [GAIN_W-1:0] GAIN_INV = GAIN_W'(652032874);
    localparam logic [ACC_W-1:0]  ACC_PI   = 32'h8000_0000;
    localparam logic [ACC_W-1:0]  ACC_HALF = 32'h0000_8000;

    localparam logic signed [ANG_W-1:0] EL_MAX = 16'sd16384;
    localparam logic signed [ANG_W-1:0] EL_MIN = -16'sd16384;

    typedef logic signed [DP_W-1:0]  t_dp;
    typedef logic        [MAG_W-1:0] t_mag;
    typedef logic        [ACC_W-1:0] t_acc;
    typedef logic        [IDX_W-1:0] t_idx;

    typedef struct packed {
        t_acc                           az;
        logic signed [COORD_WIDTH-1:0]  z;
        logic                           last;
        logic                           zero_vec;
        logic                           planar_zero;
    } t_side;

    typedef struct packed {
        logic signed [ANG_W-1:0]        azimuth;
        logic signed [ANG_W-1:0]        elevation;
        logic [COORD_WIDTH-1:0]         vector_length;
        logic                           last_out;
    } t_res;

    localparam t_acc ATAN_TABLE [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    function automatic t_acc atan_of(input t_idx idx);
        t_acc v;
        v = '0;
        if (int'(idx) < TABLE_LEN) begin
            v = ATAN_TABLE[idx];
        end
        return v;
    endfunction

endpackage

// File: design/c2s_in_if.sv
// ----------------------------------------------------------------------------
// c2s_in_if
// Input channel: one cartesian vector per transaction
// ----------------------------------------------------------------------------
interface c2s_in_if;
    import c2s_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic signed [COORD_WIDTH-1:0] z_coord;
    logic                          last_in;

    modport source (output valid, output x_coord, output y_coord, output z_coord,
                    output last_in, input ready);
    modport sink   (input valid, input x_coord, input y_coord, input z_coord,
                    input last_in, output ready);
endinterface

// File: design/c2s_out_if.sv
// ----------------------------------------------------------------------------
// c2s_out_if
// Output channel: one spherical result per transaction
// ----------------------------------------------------------------------------
interface c2s_out_if;
    import c2s_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [ANG_W-1:0]       azimuth;
    logic signed [ANG_W-1:0]       elevation;
    logic [COORD_WIDTH-1:0]        vector_length;
    logic                          last_out;

    modport source (output valid, output azimuth, output elevation,
                    output vector_length, output last_out, input ready);
    modport sink   (input valid, input azimuth, input elevation,
                    input vector_length, input last_out, output ready);
endinterface

// File: design/c2s_prep.sv
// ----------------------------------------------------------------------------
// c2s_prep
// Entry stage: scales the vector, folds the left half plane and flags the
// zero cases
// ----------------------------------------------------------------------------
module c2s_prep (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] i_x,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] i_y,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] i_z,
    input  logic                                  i_last,
    output logic                                  o_valid,
    output c2s_pkg::t_dp                          o_x,
    output c2s_pkg::t_dp                          o_y,
    output c2s_pkg::t_acc                         o_acc,
    output c2s_pkg::t_side                        o_side
);
    import c2s_pkg::*;

    logic  r_valid;
    t_dp   r_x, r_y, n_x, n_y, sx, sy;
    t_acc  r_acc, n_acc;
    t_side r_side, n_side;

    always_comb begin
        sx    = t_dp'(i_x) <<< GUARD_BITS;
        sy    = t_dp'(i_y) <<< GUARD_BITS;
        n_x   = sx;
        n_y   = sy;
        n_acc = '0;
        if (i_x < 0) begin
            n_x   = -sx;
            n_y   = -sy;
            n_acc = ACC_PI;
        end
        n_side.az          = '0;
        n_side.z           = i_z;
        n_side.last        = i_last;
        n_side.planar_zero = (i_x == '0) && (i_y == '0);
        n_side.zero_vec    = (i_x == '0) && (i_y == '0) && (i_z == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_acc  <= n_acc;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_acc   = r_acc;
    assign o_side  = r_side;

endmodule

// File: design/c2s_cell.sv
// ----------------------------------------------------------------------------
// c2s_cell
// One vectoring rotation step, registered, with the side data riding along
// ----------------------------------------------------------------------------
module c2s_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  c2s_pkg::t_idx  i_stage,
    input  logic           i_valid,
    input  c2s_pkg::t_dp   i_x,
    input  c2s_pkg::t_dp   i_y,
    input  c2s_pkg::t_acc  i_acc,
    input  c2s_pkg::t_side i_side,
    output logic           o_valid,
    output c2s_pkg::t_dp   o_x,
    output c2s_pkg::t_dp   o_y,
    output c2s_pkg::t_acc  o_acc,
    output c2s_pkg::t_side o_side
);
    import c2s_pkg::*;

    logic  r_valid;
    t_dp   r_x, r_y, n_x, n_y, xs, ys;
    t_acc  r_acc, n_acc, ang;
    t_side r_side;

    always_comb begin
        xs  = i_x >>> i_stage;
        ys  = i_y >>> i_stage;
        ang = atan_of(i_stage);
        if (!i_y[DP_W-1]) begin
            n_x   = i_x + ys;
            n_y   = i_y - xs;
            n_acc = i_acc + ang;
        end else begin
            n_x   = i_x - ys;
            n_y   = i_y + xs;
            n_acc = i_acc - ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_acc  <= n_acc;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_acc   = r_acc;
    assign o_side  = r_side;

endmodule

// File: design/c2s_gain.sv
// ----------------------------------------------------------------------------
// c2s_gain
// Rotation gain correction: rounded multiply by the inverse gain, registered
// ----------------------------------------------------------------------------
module c2s_gain (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  c2s_pkg::t_mag  i_mag,
    input  c2s_pkg::t_acc  i_acc,
    input  c2s_pkg::t_side i_side,
    output logic           o_valid,
    output c2s_pkg::t_mag  o_mag,
    output c2s_pkg::t_acc  o_acc,
    output c2s_pkg::t_side o_side
);
    import c2s_pkg::*;

    logic              r_valid;
    logic [PROD_W-1:0] prod, rnd;
    t_mag              r_mag, n_mag;
    t_acc              r_acc;
    t_side             r_side;

    always_comb begin
        prod  = PROD_W'(i_mag) * PROD_W'(GAIN_INV);
        rnd   = prod + (PROD_W'(1) << (GAIN_W - 1));
        n_mag = rnd[GAIN_W +: MAG_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag  <= n_mag;
            r_acc  <= i_acc;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_mag   = r_mag;
    assign o_acc   = r_acc;
    assign o_side  = r_side;

endmodule

// File: design/cartesian_to_spherical.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// Vector to azimuth, elevation and length through two cascaded CORDIC
// vectoring chains, each followed by a gain correction
// ----------------------------------------------------------------------------
//  port    dir  transaction
//  i_vec   in   x_coord, y_coord, z_coord, last_in
//  o_res   out  azimuth, elevation, vector_length, last_out
//
//  one vector per cycle sustained while the skid is empty; data goes through
//  the entry stage, both rotation cell chains, two gain and output stages
//  synchronous reset clears valid bits only, no clearing pass
//  output register plus a one-entry skid; i_vec.ready falls only when the skid
//  holds a result, and the whole chain then holds
// ----------------------------------------------------------------------------
module cartesian_to_spherical (
    input  logic        i_clk,
    input  logic        i_rst_n,
    c2s_in_if.sink      i_vec,
    c2s_out_if.source   o_res
);
    import c2s_pkg::*;

    logic en;
    logic take;

    logic        v1   [0:NSTAGE];
    t_dp         x1   [0:NSTAGE];
    t_dp         y1   [0:NSTAGE];
    t_acc        a1   [0:NSTAGE];
    t_side       s1   [0:NSTAGE];

    logic        v2   [0:NSTAGE];
    t_dp         x2   [0:NSTAGE];
    t_dp         y2   [0:NSTAGE];
    t_acc        a2   [0:NSTAGE];
    t_side       s2   [0:NSTAGE];

    t_mag        g1_in_mag;
    t_acc        g1_in_acc;
    logic        g1_valid, g2_valid;
    t_mag        g1_mag, g2_mag;
    t_acc        g1_acc, g2_acc;
    t_side       g1_side, g2_side;

    logic [LENR_W-1:0]       len_r;
    logic [ACC_W:0]          el_sum;
    logic signed [ANG_W:0]   el_w;
    t_acc                    az_sum;
    t_res                    res;

    logic r_out_valid, r_skid_valid;
    t_res r_out, r_skid;

    assign en          = !r_skid_valid;
    assign take        = r_out_valid && o_res.ready;
    assign i_vec.ready = en;

    c2s_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_vec.valid),
        .i_x     (i_vec.x_coord),
        .i_y     (i_vec.y_coord),
        .i_z     (i_vec.z_coord),
        .i_last  (i_vec.last_in),
        .o_valid (v1[0]),
        .o_x     (x1[0]),
        .o_y     (y1[0]),
        .o_acc   (a1[0]),
        .o_side  (s1[0])
    );

    for (genvar k = 0; k < NSTAGE; k++) begin : g_az
        c2s_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (IDX_W'(k)),
            .i_valid (v1[k]),
            .i_x     (x1[k]),
            .i_y     (y1[k]),
            .i_acc   (a1[k]),
            .i_side  (s1[k]),
            .o_valid (v1[k+1]),
            .o_x     (x1[k+1]),
            .o_y     (y1[k+1]),
            .o_acc   (a1[k+1]),
            .o_side  (s1[k+1])
        );
    end

    always_comb begin
        g1_in_mag = s1[NSTAGE].planar_zero ? '0 : x1[NSTAGE][MAG_W-1:0];
        g1_in_acc = s1[NSTAGE].planar_zero ? '0 : a1[NSTAGE];
    end

    c2s_gain u_gain_planar (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v1[NSTAGE]),
        .i_mag   (g1_in_mag),
        .i_acc   (g1_in_acc),
        .i_side  (s1[NSTAGE]),
        .o_valid (g1_valid),
        .o_mag   (g1_mag),
        .o_acc   (g1_acc),
        .o_side  (g1_side)
    );

    always_comb begin
        v2[0]    = g1_valid;
        x2[0]    = $signed({1'b0, g1_mag});
        y2[0]    = t_dp'(g1_side.z) <<< GUARD_BITS;
        a2[0]    = '0;
        s2[0]    = g1_side;
        s2[0].az = g1_acc;
    end

    for (genvar k = 0; k < NSTAGE; k++) begin : g_el
        c2s_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (IDX_W'(k)),
            .i_valid (v2[k]),
            .i_x     (x2[k]),
            .i_y     (y2[k]),
            .i_acc   (a2[k]),
            .i_side  (s2[k]),
            .o_valid (v2[k+1]),
            .o_x     (x2[k+1]),
            .o_y     (y2[k+1]),
            .o_acc   (a2[k+1]),
            .o_side  (s2[k+1])
        );
    end

    c2s_gain u_gain_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v2[NSTAGE]),
        .i_mag   (x2[NSTAGE][MAG_W-1:0]),
        .i_acc   (a2[NSTAGE]),
        .i_side  (s2[NSTAGE]),
        .o_valid (g2_valid),
        .o_mag   (g2_mag),
        .o_acc   (g2_acc),
        .o_side  (g2_side)
    );

    // result formatting: rounding, saturation, clamping and the zero vector case
    always_comb begin
        len_r  = LENR_W'(({1'b0, g2_mag} + (MAG_W+1)'(1 << (GUARD_BITS - 1))) >> GUARD_BITS);
        el_sum = {g2_acc[ACC_W-1], g2_acc} + {1'b0, ACC_HALF};
        el_w   = $signed(el_sum[ACC_W -: (ANG_W + 1)]);
        az_sum = g2_side.az + ACC_HALF;

        res.azimuth  = $signed(az_sum[ACC_W-1 -: ANG_W]);
        res.last_out = g2_side.last;
        if (len_r[LENR_W-1:COORD_WIDTH] != '0) begin
            res.vector_length = '1;
        end else begin
            res.vector_length = len_r[COORD_WIDTH-1:0];
        end
        if (el_w > (ANG_W+1)'(EL_MAX)) begin
            res.elevation = EL_MAX;
        end else if (el_w < (ANG_W+1)'(EL_MIN)) begin
            res.elevation = EL_MIN;
        end else begin
            res.elevation = el_w[ANG_W-1:0];
        end
        if (g2_side.zero_vec) begin
            res.azimuth       = '0;
            res.elevation     = '0;
            res.vector_length = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (g2_valid) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (g2_valid) begin
            if (!r_out_valid || take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.azimuth       = r_out.azimuth;
    assign o_res.elevation     = r_out.elevation;
    assign o_res.vector_length = r_out.vector_length;
    assign o_res.last_out      = r_out.last_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while the output register is empty");

    a_tail_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (g2_valid && !en) |=> (g2_valid && $stable(g2_acc) && $stable(g2_mag)))
        else $error("chain tail changed during a stall");

    a_el_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.elevation <= EL_MAX && r_out.elevation >= EL_MIN))
        else $error("elevation outside the quarter turn");

endmodule

// File: test/c2s_result_checker.sv
// ----------------------------------------------------------------------------
// c2s_result_checker
// Watches both channels of the cartesian to spherical converter, computes
// the expected azimuth, elevation and length of every accepted vector with
// its own bit-exact cordic model, and compares each result transaction in
// order against the oldest outstanding expectation
// ----------------------------------------------------------------------------
module c2s_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    c2s_in_if    i_vec,
    c2s_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import c2s_pkg::*;

    localparam logic [63:0] LEN_MAX = (64'd1 << COORD_WIDTH) - 64'd1;

    t_res results_due [$];
    int   fail_count = 0;
    int   due_count  = 0;
    int   result_idx = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = due_count;

    task automatic note_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $time, result_idx, msg);
        fail_count++;
    endtask

    // cordic vectoring: drives b toward zero, returns the accumulated angle
    function automatic t_acc vectoring_angle(inout longint a, inout longint b,
                                             input t_acc acc);
        longint a0;
        for (int i = 0; i < NSTAGE; i++) begin
            a0 = a;
            if (b >= 0) begin
                a   = a + (b >>> i);
                b   = b - (a0 >>> i);
                acc = acc + ATAN_TABLE[i];
            end else begin
                a   = a - (b >>> i);
                b   = b + (a0 >>> i);
                acc = acc - ATAN_TABLE[i];
            end
        end
        return acc;
    endfunction

    function automatic logic [63:0] gain_corrected(input logic [63:0] mag);
        logic [63:0] hi;
        logic [63:0] lo;
        hi = (mag >> 32) * 64'(GAIN_INV);
        lo = (mag & 64'hFFFF_FFFF) * 64'(GAIN_INV);
        return (hi << 2) + ((lo + (64'd1 << 29)) >> 30);
    endfunction

    function automatic t_res spherical_of(input logic signed [COORD_WIDTH-1:0] x,
                                          input logic signed [COORD_WIDTH-1:0] y,
                                          input logic signed [COORD_WIDTH-1:0] z,
                                          input logic last);
        t_res        r;
        longint      px;
        longint      py;
        longint      pz;
        longint      lx;
        longint      el_s;
        longint      el;
        t_acc        az_acc;
        t_acc        el_acc;
        t_acc        az_round;
        logic [63:0] planar;
        logic [63:0] len;
        r.azimuth       = '0;
        r.elevation     = '0;
        r.vector_length = '0;
        r.last_out      = last;
        if (x == 0 && y == 0 && z == 0) begin
            return r;
        end
        px     = longint'(x) <<< GUARD_BITS;
        py     = longint'(y) <<< GUARD_BITS;
        az_acc = '0;
        if (px < 0) begin
            px     = -px;
            py     = -py;
            az_acc = ACC_PI;
        end
        if (x == 0 && y == 0) begin
            planar = '0;
            az_acc = '0;
        end else begin
            az_acc = vectoring_angle(px, py, az_acc);
            planar = gain_corrected(64'(px));
        end
        lx     = longint'(planar);
        pz     = longint'(z) <<< GUARD_BITS;
        el_acc = vectoring_angle(lx, pz, '0);
        len    = gain_corrected(64'(lx));
        len    = (len + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
        if (len > LEN_MAX) begin
            len = LEN_MAX;
        end
        el_s = longint'($signed(el_acc));
        el   = (el_s + 32768) >>> 16;
        if (el > longint'(EL_MAX)) begin
            el = longint'(EL_MAX);
        end
        if (el < longint'(EL_MIN)) begin
            el = longint'(EL_MIN);
        end
        az_round        = az_acc + ACC_HALF;
        r.azimuth       = az_round[31:16];
        r.elevation     = el[ANG_W-1:0];
        r.vector_length = len[COORD_WIDTH-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_res due;
        if (!i_rst_n) begin
            results_due.delete();
            due_count <= 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (results_due.size() == 0) begin
                    note_mismatch($sformatf("unexpected transaction az %0d el %0d len %0d",
                                            i_res.azimuth, i_res.elevation,
                                            i_res.vector_length));
                end else begin
                    due = results_due.pop_front();
                    if (i_res.azimuth !== due.azimuth) begin
                        note_mismatch($sformatf("azimuth got %0d expected %0d",
                                                i_res.azimuth, due.azimuth));
                    end
                    if (i_res.elevation !== due.elevation) begin
                        note_mismatch($sformatf("elevation got %0d expected %0d",
                                                i_res.elevation, due.elevation));
                    end
                    if (i_res.vector_length !== due.vector_length) begin
                        note_mismatch($sformatf("vector_length got %0d expected %0d",
                                                i_res.vector_length, due.vector_length));
                    end
                    if (i_res.last_out !== due.last_out) begin
                        note_mismatch($sformatf("last_out got %0b expected %0b",
                                                i_res.last_out, due.last_out));
                    end
                end
                result_idx++;
            end
            if (i_vec.valid && i_vec.ready) begin
                results_due.push_back(spherical_of(i_vec.x_coord, i_vec.y_coord,
                                                   i_vec.z_coord, i_vec.last_in));
            end
            due_count <= results_due.size();
        end
    end

endmodule

// File: test/cartesian_to_spherical_tb.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical_tb
// Drives directed corner vectors and a long random vector stream into the
// converter under random sender and receiver idling, a long output stall
// and a full drain, while the result checker predicts and compares
// ----------------------------------------------------------------------------
module cartesian_to_spherical_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import c2s_pkg::*;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    localparam t_coord C_MAX       = t_coord'((1 << (COORD_WIDTH - 1)) - 1);
    localparam t_coord C_MIN       = t_coord'(-(1 << (COORD_WIDTH - 1)));
    localparam int     HOLD_CYCLES = 300;
    localparam int     DRAIN_WAIT  = 2 * NSTAGE + 8;
    localparam int     RUN_LIMIT   = 400000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   tx_idle_pct   = 36;
    int   rx_idle_pct   = 74;
    int   hold_requests = 0;
    int   holds_done    = 0;
    int   hold_left     = 0;
    int   cycle_cnt     = 0;

    c2s_in_if  vec ();
    c2s_out_if res ();

    cartesian_to_spherical dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (vec),
        .o_res   (res)
    );

    c2s_result_checker result_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vec        (vec),
        .i_res        (res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_cnt < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random back-pressure plus long hold-off on request
    initial begin
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_done) begin
                holds_done = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                res.ready <= 1'b0;
                hold_left--;
            end else begin
                res.ready <= (int'($urandom_range(99)) >= rx_idle_pct);
            end
        end
    end

    task automatic send_vec(input t_coord x, input t_coord y, input t_coord z,
                            input logic last);
        while (int'($urandom_range(99)) < tx_idle_pct) begin
            vec.valid <= 1'b0;
            @(posedge i_clk);
        end
        vec.valid   <= 1'b1;
        vec.x_coord <= x;
        vec.y_coord <= y;
        vec.z_coord <= z;
        vec.last_in <= last;
        @(posedge i_clk);
        while (!vec.ready) @(posedge i_clk);
    endtask

    function automatic t_coord corner_coord();
        t_coord c;
        case ($urandom_range(5))
            0:       c = C_MAX;
            1:       c = C_MIN;
            2:       c = '1;
            3:       c = t_coord'(1);
            4:       c = '0;
            default: c = t_coord'($urandom());
        endcase
        return c;
    endfunction

    function automatic t_coord small_coord(input int span);
        return t_coord'(int'($urandom_range(2 * span)) - span);
    endfunction

    task automatic send_random(input int count);
        t_coord x;
        t_coord y;
        t_coord z;
        logic   last;
        for (int n = 0; n < count; n++) begin
            x    = t_coord'($urandom());
            y    = t_coord'($urandom());
            z    = t_coord'($urandom());
            last = ($urandom_range(7) == 0);
            case ($urandom_range(9))
                4: z = '0;
                5: begin
                    x = small_coord(32);
                    y = small_coord(32);
                    z = small_coord(32);
                end
                6: begin
                    if ($urandom_range(1) == 1) x = '0;
                    if ($urandom_range(1) == 1) y = '0;
                    if ($urandom_range(1) == 1) z = '0;
                end
                7: begin
                    x = corner_coord();
                    y = corner_coord();
                    z = corner_coord();
                end
                // close to the negative x axis, where azimuth wraps
                8: begin
                    x = t_coord'(int'(C_MIN) + int'($urandom_range(3)));
                    y = small_coord(3);
                    z = ($urandom_range(1) == 1) ? '0 : small_coord(3);
                end
                // nearly vertical
                9: begin
                    x = small_coord(4);
                    y = small_coord(4);
                end
                default: ;
            endcase
            send_vec(x, y, z, last);
        end
    endtask

    task automatic wait_results_drained();
        vec.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        vec.valid   <= 1'b0;
        vec.x_coord <= '0;
        vec.y_coord <= '0;
        vec.z_coord <= '0;
        vec.last_in <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        tx_idle_pct = 36;
        rx_idle_pct = 74;
        send_vec('0, '0, '0, 1'b0);
        send_vec('0, '0, '0, 1'b1);
        send_vec(C_MAX, '0, '0, 1'b0);
        send_vec(C_MIN, '0, '0, 1'b0);
        send_vec('1, '0, '0, 1'b1);
        send_vec(t_coord'(1), '0, '0, 1'b0);
        send_vec('0, C_MAX, '0, 1'b0);
        send_vec('0, C_MIN, '0, 1'b0);
        send_vec('0, '0, C_MAX, 1'b0);
        send_vec('0, '0, C_MIN, 1'b1);
        send_vec('0, '0, t_coord'(1), 1'b0);
        send_vec('0, '0, '1, 1'b0);
        send_vec(C_MAX, C_MAX, C_MAX, 1'b0);
        send_vec(C_MIN, C_MIN, C_MIN, 1'b1);
        send_vec(C_MAX, C_MIN, '0, 1'b0);
        send_vec(C_MIN, C_MAX, C_MIN, 1'b0);
        send_vec(C_MIN, t_coord'(1), '0, 1'b0);
        send_vec(C_MIN, '1, '0, 1'b0);
        send_vec('1, '1, '1, 1'b1);
        send_vec(t_coord'(1), t_coord'(1), t_coord'(1), 1'b0);
        send_vec(C_MAX, t_coord'(1), C_MIN, 1'b0);
        send_vec('1, C_MAX, C_MAX, 1'b1);

        send_random(600);

        tx_idle_pct = 74;
        rx_idle_pct = 36;
        send_random(600);

        // long output stall while the sender keeps pushing
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests++;
        send_random(120);
        wait_results_drained();

        send_random(510);
        wait_results_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
